[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define JDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also checks across reset
`define JDM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/jdm_pkg.sv]
// types and constants of the joystick drive mixer
package jdm_pkg;

  localparam int MAG_W    = 7;
  localparam int SPEED_W  = 19;
  localparam int FRAC_W   = 8;
  localparam int CUBE_W   = 20;
  localparam int SUM_W    = 22;
  localparam int SMAG_W   = 21;
  localparam int NUM_W    = 25;
  localparam int DEN_W    = 15;
  localparam int QUO_W    = 13;
  localparam int TGT_W    = 11;
  localparam int GAP_W    = 20;
  localparam int SP_W     = 28;
  localparam int CUB_AW   = 14;
  localparam int CUB_BW   = 7;
  localparam int SCL_AW   = 21;
  localparam int SCL_BW   = 9;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [7:0]        AXIS_LIMIT  = 8'd100;
  localparam logic [QUO_W-1:0]  TGT_POS_MAX = 13'd1023;
  localparam logic [QUO_W-1:0]  TGT_NEG_MAX = 13'd1024;
  localparam logic [SCL_BW-1:0] ALPHA_MAX   = 9'd256;

  localparam logic [6:0] DZ_RST     = 7'd5;
  localparam logic [3:0] GAIN_RST   = 4'd6;
  localparam logic [8:0] SMOOTH_RST = 9'd26;

  typedef enum logic [1:0] {
    REG_DEADZONE  = 2'd0,
    REG_GAIN      = 2'd1,
    REG_SMOOTHING = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] deadzone;
    logic [3:0] gain;
    logic [8:0] smoothing;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CUBE,
    ST_GAIN,
    ST_DIV,
    ST_SLEW,
    ST_SEND
  } st_t;

endpackage

[sv/jdm_smul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
module jdm_smul #(
  parameter int AW = 14,
  parameter int BW = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output logic              done,
  output logic [AW+BW-1:0]  prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_r, a_nxt;
  logic [AW+BW-1:0] p_r, p_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [AW:0]      upper;

  always_comb begin
    upper    = {1'b0, p_r[AW+BW-1:BW]} + {1'b0, (p_r[0] ? a_r : AW'(0))};
    a_nxt    = a_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = a;
      p_nxt   = {{AW{1'b0}}, b};
      cnt_nxt = CW'(BW);
    end else if (cnt_r != '0) begin
      p_nxt    = {upper, p_r[BW-1:1]};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    p_r <= p_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

[sv/jdm_sdiv.sv]
// restoring divider, one quotient bit per cycle
module jdm_sdiv
  import jdm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int CW = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] q_r, q_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W+1:0] trial;

  always_comb begin
    trial    = {1'b0, rem_r, q_r[QUO_W-1]} - {2'b00, den_r};
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      den_nxt = den;
      rem_nxt = DEN_W'(num[NUM_W-1:QUO_W]);
      q_nxt   = num[QUO_W-1:0];
      cnt_nxt = CW'(QUO_W);
    end else if (cnt_r != '0) begin
      if (trial[DEN_W+1]) begin
        rem_nxt = {rem_r[DEN_W-2:0], q_r[QUO_W-1]};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
      end
      q_nxt    = {q_r[QUO_W-2:0], ~trial[DEN_W+1]};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

[sv/jdm_ctrl.sv]
// sequencer and datapath: mixing, division, slew filter and result register
module jdm_ctrl
  import jdm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic signed [7:0]         in_stick_x,
  input  logic signed [7:0]         in_stick_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SPEED_W-1:0] out_left_speed,
  output logic signed [SPEED_W-1:0] out_right_speed,
  output logic                      out_brake
);

  st_t st_r, st_nxt;

  logic [7:0]       ax8, ay8;
  logic [MAG_W-1:0] axm, aym;
  logic [7:0]       tsum;
  logic [DEN_W-1:0] den_in;
  logic             range_bad, acc, go, brk;

  logic [MAG_W-1:0] axm_r, aym_r;
  logic             sx_r, sy_r;
  logic [DEN_W-1:0] den_r;
  logic             sl_neg_r, sr_neg_r, gl_neg_r, gr_neg_r;
  logic             brake_r, brake_nxt;
  logic signed [SPEED_W-1:0] ls_r, ls_nxt, rs_r, rs_nxt;

  logic             out_valid_r, out_valid_nxt, out_brake_r;
  logic signed [SPEED_W-1:0] out_left_r, out_right_r;
  logic             out_free;

  logic cub_start, scl_start, div_start, load_out;
  logic cub_done_x, cub_done_y, cub_done;
  logic scl_done_l, scl_done_r, scl_done;
  logic div_done_l, div_done_r, div_done;

  logic [CUB_AW-1:0]        cub_ax, cub_ay;
  logic [CUB_BW-1:0]        cub_bx, cub_by;
  logic [CUB_AW+CUB_BW-1:0] prod_x, prod_y;

  logic signed [SUM_W-1:0]  cxs, cys, sl, sr, slm, srm;
  logic [SCL_AW-1:0]        scl_al, scl_ar;
  logic [SCL_BW-1:0]        scl_b, alpha_c;
  logic [SCL_AW+SCL_BW-1:0] prod_l, prod_r;

  logic [QUO_W-1:0]         quo_l, quo_r, qcl, qcr;
  logic signed [TGT_W-1:0]  tl, tr;
  logic signed [GAP_W-1:0]  gl, gr, glm, grm;
  logic signed [SP_W-1:0]   spl, spr;

  // front end: range check, deadzone, denominator 100*t
  always_comb begin
    ax8       = in_stick_x[7] ? (~in_stick_x + 8'd1) : in_stick_x;
    ay8       = in_stick_y[7] ? (~in_stick_y + 8'd1) : in_stick_y;
    range_bad = (ax8 > AXIS_LIMIT) || (ay8 > AXIS_LIMIT);
    axm       = (ax8[MAG_W-1:0] < cfg.deadzone) ? '0 : ax8[MAG_W-1:0];
    aym       = (ay8[MAG_W-1:0] < cfg.deadzone) ? '0 : ay8[MAG_W-1:0];
    tsum      = {1'b0, axm} + {1'b0, aym};
    den_in    = (DEN_W'(tsum) << 6) + (DEN_W'(tsum) << 5) + (DEN_W'(tsum) << 2);
    acc       = in_valid && !in_stall;
    go        = acc && !in_req_type && !range_bad && (tsum != 8'd0);
    brk       = acc && in_req_type;
  end

  assign cub_done = cub_done_x & cub_done_y;
  assign scl_done = scl_done_l & scl_done_r;
  assign div_done = div_done_l & div_done_r;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (go) begin
          st_nxt = ST_SQUARE;
        end else if (brk) begin
          st_nxt = ST_SEND;
        end
      end
      ST_SQUARE: if (cub_done) st_nxt = ST_CUBE;
      ST_CUBE:   if (cub_done) st_nxt = ST_GAIN;
      ST_GAIN:   if (scl_done) st_nxt = ST_DIV;
      ST_DIV:    if (div_done) st_nxt = ST_SLEW;
      ST_SLEW:   if (scl_done) st_nxt = ST_SEND;
      ST_SEND:   if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    cub_start = 1'b0;
    scl_start = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cub_start = go;
      end
      ST_SQUARE: cub_start = cub_done;
      ST_CUBE:   scl_start = cub_done;
      ST_GAIN:   div_start = scl_done;
      ST_DIV:    scl_start = div_done;
      ST_SLEW:   ;
      ST_SEND:   load_out = out_free;
      default:   ;
    endcase
  end

  // cube lanes: |a|*|a| then |a|^2*|a|
  always_comb begin
    if (st_r == ST_IDLE) begin
      cub_ax = CUB_AW'(axm);
      cub_ay = CUB_AW'(aym);
      cub_bx = axm;
      cub_by = aym;
    end else begin
      cub_ax = prod_x[CUB_AW-1:0];
      cub_ay = prod_y[CUB_AW-1:0];
      cub_bx = axm_r;
      cub_by = aym_r;
    end
  end

  jdm_smul #(.AW(CUB_AW), .BW(CUB_BW)) u_cub_x (
    .clk(clk), .rst_n(rst_n), .start(cub_start), .a(cub_ax), .b(cub_bx),
    .done(cub_done_x), .prod(prod_x)
  );

  jdm_smul #(.AW(CUB_AW), .BW(CUB_BW)) u_cub_y (
    .clk(clk), .rst_n(rst_n), .start(cub_start), .a(cub_ay), .b(cub_by),
    .done(cub_done_y), .prod(prod_y)
  );

  // signed mix of the cubes
  always_comb begin
    cxs = SUM_W'(prod_x[CUBE_W-1:0]);
    cys = SUM_W'(prod_y[CUBE_W-1:0]);
    if (sx_r) cxs = -cxs;
    if (sy_r) cys = -cys;
    sl  = cxs + cys;
    sr  = cxs - cys;
    slm = sl[SUM_W-1] ? -sl : sl;
    srm = sr[SUM_W-1] ? -sr : sr;
  end

  // saturated targets and gaps to the smoothed speeds
  always_comb begin
    if (sl_neg_r) begin
      qcl = (quo_l > TGT_NEG_MAX) ? TGT_NEG_MAX : quo_l;
      tl  = TGT_W'(0) - TGT_W'(qcl);
    end else begin
      qcl = (quo_l > TGT_POS_MAX) ? TGT_POS_MAX : quo_l;
      tl  = TGT_W'(qcl);
    end
    if (sr_neg_r) begin
      qcr = (quo_r > TGT_NEG_MAX) ? TGT_NEG_MAX : quo_r;
      tr  = TGT_W'(0) - TGT_W'(qcr);
    end else begin
      qcr = (quo_r > TGT_POS_MAX) ? TGT_POS_MAX : quo_r;
      tr  = TGT_W'(qcr);
    end
    gl      = GAP_W'($signed({tl, {FRAC_W{1'b0}}})) - GAP_W'(ls_r);
    gr      = GAP_W'($signed({tr, {FRAC_W{1'b0}}})) - GAP_W'(rs_r);
    glm     = gl[GAP_W-1] ? -gl : gl;
    grm     = gr[GAP_W-1] ? -gr : gr;
    alpha_c = (cfg.smoothing > ALPHA_MAX) ? ALPHA_MAX : cfg.smoothing;
  end

  // scale lanes: gain on the mix, then alpha on the gap
  always_comb begin
    if (st_r == ST_CUBE) begin
      scl_al = slm[SMAG_W-1:0];
      scl_ar = srm[SMAG_W-1:0];
      scl_b  = SCL_BW'(cfg.gain);
    end else begin
      scl_al = SCL_AW'(glm[GAP_W-1:0]);
      scl_ar = SCL_AW'(grm[GAP_W-1:0]);
      scl_b  = alpha_c;
    end
  end

  jdm_smul #(.AW(SCL_AW), .BW(SCL_BW)) u_scl_l (
    .clk(clk), .rst_n(rst_n), .start(scl_start), .a(scl_al), .b(scl_b),
    .done(scl_done_l), .prod(prod_l)
  );

  jdm_smul #(.AW(SCL_AW), .BW(SCL_BW)) u_scl_r (
    .clk(clk), .rst_n(rst_n), .start(scl_start), .a(scl_ar), .b(scl_b),
    .done(scl_done_r), .prod(prod_r)
  );

  jdm_sdiv u_div_l (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(prod_l[NUM_W-1:0]),
    .den(den_r), .done(div_done_l), .quo(quo_l)
  );

  jdm_sdiv u_div_r (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(prod_r[NUM_W-1:0]),
    .den(den_r), .done(div_done_r), .quo(quo_r)
  );

  // slew step with flooring shift
  always_comb begin
    spl = SP_W'(prod_l[SP_W-2:0]);
    spr = SP_W'(prod_r[SP_W-2:0]);
    if (gl_neg_r) spl = -spl;
    if (gr_neg_r) spr = -spr;
    ls_nxt    = ls_r;
    rs_nxt    = rs_r;
    brake_nxt = brake_r;
    if (brk) begin
      ls_nxt    = '0;
      rs_nxt    = '0;
      brake_nxt = 1'b1;
    end else if (go) begin
      brake_nxt = 1'b0;
    end else if ((st_r == ST_SLEW) && scl_done) begin
      ls_nxt = ls_r + SPEED_W'(spl >>> FRAC_W);
      rs_nxt = rs_r + SPEED_W'(spr >>> FRAC_W);
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      axm_r <= axm;
      aym_r <= aym;
      sx_r  <= in_stick_x[7];
      sy_r  <= in_stick_y[7];
      den_r <= den_in;
    end
    if ((st_r == ST_CUBE) && cub_done) begin
      sl_neg_r <= sl[SUM_W-1];
      sr_neg_r <= sr[SUM_W-1];
    end
    if ((st_r == ST_DIV) && div_done) begin
      gl_neg_r <= gl[GAP_W-1];
      gr_neg_r <= gr[GAP_W-1];
    end
    if (load_out) begin
      out_left_r  <= ls_r;
      out_right_r <= rs_r;
      out_brake_r <= brake_r;
    end
    brake_r <= brake_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ls_r        <= '0;
      rs_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ls_r        <= ls_nxt;
      rs_r        <= rs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_speed  = out_left_r;
  assign out_right_speed = out_right_r;
  assign out_brake       = out_brake_r;

endmodule

[sv/joystick_drive_mixer_unit.sv]
// joystick drive mixer: apb register file and mixer core
//
// input channel (in_*): one joystick sample per transfer, req_type 0 is a
// drive sample with stick_x/stick_y, req_type 1 is a stop with brake.
// output channel (out_*): left/right smoothed speeds in q8 and a brake flag.
// a drive sample with an axis beyond +-100, or with both axes inside the
// deadzone, is consumed and gives no result.
// a drive sample goes through the bit-serial passes of the multipliers and
// dividers in turn: squaring, cubing, gain, quotient and alpha.
// one sample is worked on at a time; a stop goes through the send state to
// the output register, a dropped sample frees the input in the next cycle.
// the result sits in an output register; while out_stall is high it holds,
// and the next sample can be taken but its result waits for the register.
// reset (rst_n low, synchronous) clears both smoothed speeds, the output
// valid and loads deadzone 5, gain 6, smoothing 26.
// registers at byte addresses 0, 4, 8: deadzone, gain, smoothing.
module joystick_drive_mixer_unit
  import jdm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic signed [7:0]         in_stick_x,
  input  logic signed [7:0]         in_stick_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [SPEED_W-1:0] out_left_speed,
  output logic signed [SPEED_W-1:0] out_right_speed,
  output logic                      out_brake
);

  cfg_t     cfg_r, cfg_nxt;
  logic     wr_en;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_DEADZONE:  cfg_nxt.deadzone  = pwdata[6:0];
        REG_GAIN:      cfg_nxt.gain      = pwdata[3:0];
        REG_SMOOTHING: cfg_nxt.smoothing = pwdata[8:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEADZONE:  prdata = DATA_W'(cfg_r.deadzone);
      REG_GAIN:      prdata = DATA_W'(cfg_r.gain);
      REG_SMOOTHING: prdata = DATA_W'(cfg_r.smoothing);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone  <= DZ_RST;
      cfg_r.gain      <= GAIN_RST;
      cfg_r.smoothing <= SMOOTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jdm_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_stick_x      (in_stick_x),
    .in_stick_y      (in_stick_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_speed  (out_left_speed),
    .out_right_speed (out_right_speed),
    .out_brake       (out_brake)
  );

endmodule

[sv/jdm_checker.sv]
// port-level checker for the joystick drive mixer and its bind
`include "assert_macros.svh"

module jdm_checker
  import jdm_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      in_req_type,
  input logic signed [7:0]         in_stick_x,
  input logic signed [7:0]         in_stick_y,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [SPEED_W-1:0] out_left_speed,
  input logic signed [SPEED_W-1:0] out_right_speed,
  input logic                      out_brake
);

  logic axis_bad;

  assign axis_bad = (in_stick_x > 8'sd100) || (in_stick_x < -8'sd100) ||
                    (in_stick_y > 8'sd100) || (in_stick_y < -8'sd100);

  `JDM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_left_speed) && $stable(out_right_speed) && $stable(out_brake), "stalled result changed")
  `JDM_ASSERT(a_brake_zero, out_valid && out_brake |-> (out_left_speed == '0) && (out_right_speed == '0), "brake result with nonzero speed")
  `JDM_ASSERT(a_stop_busy, in_valid && !in_stall && in_req_type |=> in_stall, "stop transfer did not occupy the block")
  `JDM_ASSERT(a_drop_free, in_valid && !in_stall && !in_req_type && axis_bad |=> !in_stall, "out-of-range sample not dropped")
  `JDM_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind joystick_drive_mixer_unit jdm_checker u_jdm_checker (.*);

[verif/testbench.sv]
// self-checking testbench for the joystick drive mixer with its own mixing and slew predictor
`timescale 1ns / 100ps

module testbench;
  import jdm_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 64;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 115;
  localparam int IDLE_PCT     = 27;
  localparam int HOLD_CYCLES  = 500;

  typedef struct {
    logic               req;
    logic signed [7:0]  x;
    logic signed [7:0]  y;
  } sample_t;

  typedef struct {
    logic signed [SPEED_W-1:0] left;
    logic signed [SPEED_W-1:0] right;
    logic                      brake;
  } speed_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_req_type = 1'b0;
  logic signed [7:0]         in_stick_x = '0;
  logic signed [7:0]         in_stick_y = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [SPEED_W-1:0] out_left_speed;
  logic signed [SPEED_W-1:0] out_right_speed;
  logic                      out_brake;

  joystick_drive_mixer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_stick_x      (in_stick_x),
    .in_stick_y      (in_stick_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_speed  (out_left_speed),
    .out_right_speed (out_right_speed),
    .out_brake       (out_brake)
  );

  // predictor state and register copy
  cfg_t   cfg_q = '{deadzone: DZ_RST, gain: GAIN_RST, smoothing: SMOOTH_RST};
  longint left_sm = 0;
  longint right_sm = 0;

  sample_t stick_q[$];
  speed_t  expected_speeds[$];

  int  errors = 0;
  int  accepted = 0;
  int  dropped = 0;
  int  checked = 0;
  int  brakes = 0;
  int  settings = 1;
  int  cycles = 0;
  int  hold_left = 0;
  bit  did_hold = 1'b0;
  bit  calm = 1'b0;

  sample_t cur;
  speed_t  res;
  speed_t  exp_r;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint slew_step(longint s, longint tgt, longint al);
    return s + (((tgt * 256 - s) * al) >>> 8);
  endfunction

  // returns 1 when the sample gives a result
  function automatic bit mix_sample(input sample_t s, output speed_t r);
    longint x, y, ax, ay, t, cx, cy, nl, nr, tl, tr, al, dz, g;
    r = '{left: '0, right: '0, brake: 1'b0};
    if (s.req) begin
      left_sm = 0;
      right_sm = 0;
      r.brake = 1'b1;
      return 1'b1;
    end
    x = s.x;
    y = s.y;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    if (ax > 100 || ay > 100) return 1'b0;
    dz = longint'(cfg_q.deadzone);
    if (ax < dz) begin
      x = 0;
      ax = 0;
    end
    if (ay < dz) begin
      y = 0;
      ay = 0;
    end
    t = ax + ay;
    if (t == 0) return 1'b0;
    cx = x * ax * ax;
    cy = y * ay * ay;
    g = longint'(cfg_q.gain);
    nl = g * (cx + cy);
    nr = g * (cx - cy);
    tl = nl / (100 * t);
    tr = nr / (100 * t);
    tl = (tl > 1023) ? 1023 : ((tl < -1024) ? -1024 : tl);
    tr = (tr > 1023) ? 1023 : ((tr < -1024) ? -1024 : tr);
    al = longint'(cfg_q.smoothing);
    if (al > 256) al = 256;
    left_sm = slew_step(left_sm, tl, al);
    right_sm = slew_step(right_sm, tr, al);
    r.left = left_sm[SPEED_W-1:0];
    r.right = right_sm[SPEED_W-1:0];
    return 1'b1;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int sel, v, lim;
    sel = $urandom_range(0, 99);
    s.req = 1'b0;
    s.x = 8'(int'($urandom_range(0, 200)) - 100);
    s.y = 8'(int'($urandom_range(0, 200)) - 100);
    if (sel < 5) begin
      s.req = 1'b1;
      s.x = 8'($urandom);
      s.y = 8'($urandom);
    end else if (sel < 12) begin
      v = $urandom_range(101, 128);
      if ($urandom_range(0, 1)) v = -v;
      else if (v == 128) v = 127;
      if ($urandom_range(0, 1)) begin
        s.x = 8'(v);
        s.y = 8'($urandom);
      end else begin
        s.y = 8'(v);
        s.x = 8'($urandom);
      end
    end else if (sel < 26) begin
      lim = int'(cfg_q.deadzone) + 2;
      if (lim > 100) lim = 100;
      v = $urandom_range(0, lim);
      s.x = 8'($urandom_range(0, 1) ? -v : v);
      v = $urandom_range(0, lim);
      s.y = 8'($urandom_range(0, 1) ? -v : v);
    end else if (sel < 32) begin
      s.x = 8'($urandom_range(0, 1) ? -100 : 100);
      s.y = 8'($urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? -100 : 100));
    end
    return s;
  endfunction

  task automatic push_sample(input logic req, input int x, input int y);
    stick_q.push_back('{req: req, x: x[7:0], y: y[7:0]});
  endtask

  task automatic apb_write(input reg_idx_t idx, input int width, input int value);
    logic [DATA_W-1:0] word;
    word = ($urandom << width) | DATA_W'(value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DEADZONE:  cfg_q.deadzone = word[6:0];
      REG_GAIN:      cfg_q.gain = word[3:0];
      REG_SMOOTHING: cfg_q.smoothing = word[8:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int dz, input int g, input int sm);
    apb_write(REG_DEADZONE, 7, dz);
    apb_write(REG_GAIN, 4, g);
    apb_write(REG_SMOOTHING, 9, sm);
    settings++;
  endtask

  task automatic drain();
    while (stick_q.size() != 0 || in_valid || expected_speeds.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // driver: one transfer per accepted sample, random gaps between them outside the calm phase
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accepted++;
        cur = '{req: in_req_type, x: in_stick_x, y: in_stick_y};
        if (mix_sample(cur, res)) expected_speeds.push_back(res);
        else dropped++;
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (stick_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cur = stick_q.pop_front();
        in_valid <= 1'b1;
        in_req_type <= cur.req;
        in_stick_x <= cur.x;
        in_stick_y <= cur.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off counter
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!did_hold && checked >= 300 && stick_q.size() > 20) begin
      hold_left <= HOLD_CYCLES;
      did_hold <= 1'b1;
    end
  end

  // monitor: checks each result transfer against the oldest prediction and drives out_stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (out_brake) brakes++;
        if (expected_speeds.size() == 0) begin
          $error("result with nothing expected: left %0d right %0d brake %0b",
                 out_left_speed, out_right_speed, out_brake);
          errors++;
        end else begin
          exp_r = expected_speeds.pop_front();
          if (out_left_speed !== exp_r.left) begin
            $error("left_speed expected %0d actual %0d", exp_r.left, out_left_speed);
            errors++;
          end
          if (out_right_speed !== exp_r.right) begin
            $error("right_speed expected %0d actual %0d", exp_r.right, out_right_speed);
            errors++;
          end
          if (out_brake !== exp_r.brake) begin
            $error("brake expected %0b actual %0b", exp_r.brake, out_brake);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[joystick_drive_mixer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int cfgs[6][3];
    cfgs = '{'{0, 15, 256}, '{127, 6, 26}, '{0, 0, 1}, '{100, 15, 511},
             '{3, 11, 0}, '{10, 10, 128}};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed samples at reset settings
    push_sample(1'b1, 0, 0);
    push_sample(1'b0, 100, 100);
    push_sample(1'b0, -100, -100);
    push_sample(1'b0, 100, -100);
    push_sample(1'b0, -100, 100);
    push_sample(1'b0, 100, 0);
    push_sample(1'b0, 0, 100);
    push_sample(1'b0, 0, 0);
    push_sample(1'b0, 4, -4);
    push_sample(1'b0, 5, -5);
    push_sample(1'b0, 101, 0);
    push_sample(1'b0, 0, -101);
    push_sample(1'b0, -128, 127);
    push_sample(1'b0, 127, 0);
    push_sample(1'b1, -128, 127);
    push_sample(1'b0, 1, 100);
    push_sample(1'b0, -1, -99);
    push_sample(1'b0, 50, -25);
    push_sample(1'b0, 99, 3);
    push_sample(1'b1, 127, -128);
    push_sample(1'b0, -100, 0);
    push_sample(1'b0, 0, -100);
    drain();

    for (int p = 0; p < 10; p++) begin
      if (p < 6) set_config(cfgs[p][0], cfgs[p][1], cfgs[p][2]);
      else set_config($urandom_range(0, 30), $urandom_range(0, 15), $urandom_range(0, 300));
      @(negedge clk);
      calm = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) stick_q.push_back(rand_sample());
      drain();
      calm = 1'b0;
    end

    $display("%0d samples sent (%0d dropped), %0d results checked (%0d brakes)",
             accepted, dropped, checked, brakes);
    $display("%0d register settings used, long output hold-off %0s",
             settings, did_hold ? "done" : "not reached");
    if (errors == 0) begin
      $display("[joystick_drive_mixer_unit] OK");
    end else begin
      $display("[joystick_drive_mixer_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/jdm_pkg.sv
sv/jdm_smul.sv
sv/jdm_sdiv.sv
sv/jdm_ctrl.sv
sv/joystick_drive_mixer_unit.sv
sv/jdm_checker.sv
verif/testbench.sv
